// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Types, codes and shared helpers for the sixteen-source interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] line_number;
    logic       line_level;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic       int_out;
    logic [7:0] vector_out;
    logic [7:0] read_data;
    logic       spurious;
  } rsp_t;

  typedef struct packed {
    logic [15:0] line_levels;
    logic [15:0] request_bits;
    logic [15:0] service_bits;
    logic [15:0] mask_bits;
    logic [15:0] edge_select;
    logic [15:0] group_bits;
    logic [2:0]  vector_base;
    logic        illegal_flag;
    logic        vector_set;
    logic        int_state;
  } pic_state_t;

  localparam logic [2:0] CMD_LINE  = 3'd0;
  localparam logic [2:0] CMD_ACK   = 3'd1;
  localparam logic [2:0] CMD_EOI   = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // write map
  localparam logic [1:0] ADDR_EDGE_LO = 2'd0;
  localparam logic [1:0] ADDR_EDGE_HI = 2'd1;
  localparam logic [1:0] ADDR_MASK_LO = 2'd2;
  localparam logic [1:0] ADDR_MASK_HI = 2'd3;
  // read map
  localparam logic [1:0] ADDR_SRV_LO  = 2'd0;
  localparam logic [1:0] ADDR_SRV_HI  = 2'd1;
  localparam logic [1:0] ADDR_RMSK_LO = 2'd2;
  localparam logic [1:0] ADDR_RMSK_HI = 2'd3;

  localparam pic_state_t STATE_RESET = '{
    line_levels:  16'h0000,
    request_bits: 16'h0000,
    service_bits: 16'h0000,
    mask_bits:    16'hffff,
    edge_select:  16'h0000,
    group_bits:   16'h0000,
    vector_base:  3'd0,
    illegal_flag: 1'b0,
    vector_set:   1'b0,
    int_state:    1'b0
  };

  function automatic logic [3:0] top_bit(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic logic should_int(input logic [15:0] req, input logic [15:0] srv,
                                      input logic [15:0] grp, input logic ill);
    logic [15:0] hr;
    logic [15:0] hs;
    logic        r;
    hr = req & grp;
    hs = srv & grp;
    if (ill) begin
      r = 1'b0;
    end else if (hr != 16'h0000 || hs != 16'h0000) begin
      r = (req & ~srv & grp) > hs;
    end else begin
      r = (req & ~srv) > srv;
    end
    return r;
  endfunction

endpackage

// ===== rtl/prioritized_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// prioritized_interrupt_controller
// Sixteen-source vectored priority interrupt controller. Every command beat
// (line change, acknowledge, end of interrupt, register write or read)
// returns one result beat carrying the interrupt line, the acknowledge
// vector, the read byte and the spurious flag. One beat is taken per cycle
// while the consumer does not stall: a command register feeds a combinational
// update of the controller registers, and the result lands in an output
// register that holds while the consumer stalls. A command is taken while
// an earlier result is still waiting.
// ----------------------------------------------------------------------------
module prioritized_interrupt_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pic_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pic_pkg::rsp_t  rsp
);

  pic_pkg::req_t       cmd_q;
  logic                cmd_valid;
  pic_pkg::pic_state_t st;
  pic_pkg::pic_state_t st_next;
  pic_pkg::rsp_t       result;
  logic                advance;

  assign advance   = cmd_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !cmd_valid || advance;

  pic_eval u_eval (
    .st      (st),
    .item    (cmd_q),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      rsp_valid <= 1'b0;
      st        <= pic_pkg::STATE_RESET;
    end else begin
      if (req_ready) begin
        cmd_valid <= req_valid;
      end
      if (advance) begin
        st        <= st_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd_q <= req;
    end
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

// ===== rtl/pic_eval.sv =====
// ----------------------------------------------------------------------------
// pic_eval
// Single-pass state update and result for one command.
// ----------------------------------------------------------------------------
module pic_eval (
  input  pic_pkg::pic_state_t st,
  input  pic_pkg::req_t       item,
  output pic_pkg::pic_state_t st_next,
  output pic_pkg::rsp_t       result
);

  logic [15:0] hi_req;
  logic [15:0] hi_srv;
  logic [15:0] line_bit;
  logic [3:0]  ack_lvl;
  logic [15:0] ack_bit;
  logic        ack_found;
  logic [3:0]  eoi_lvl;
  logic [15:0] eoi_bit;
  logic [15:0] lo_word;
  logic [15:0] sel_word;
  logic [15:0] mask_word;
  logic [15:0] edge_req;
  logic [15:0] mask_req;
  logic [15:0] fall_req;
  logic [15:0] rise_cmp;

  assign hi_req   = st.request_bits & st.group_bits;
  assign hi_srv   = st.service_bits & st.group_bits;
  assign line_bit = 16'h0001 << item.line_number;

  assign ack_lvl  = pic_pkg::top_bit((hi_req != 16'h0000) ? hi_req : st.request_bits);
  assign ack_bit  = 16'h0001 << ack_lvl;
  assign ack_found = (hi_req != 16'h0000) ? !(ack_bit < hi_srv)
                   : (st.request_bits != 16'h0000 && hi_srv == 16'h0000 &&
                      !(ack_bit < st.service_bits));

  assign eoi_lvl  = pic_pkg::top_bit((hi_srv != 16'h0000) ? hi_srv : st.service_bits);
  assign eoi_bit  = 16'h0001 << eoi_lvl;

  // edge or group byte write, depending on the vector-set flag
  assign lo_word  = st.vector_set ? st.group_bits : st.edge_select;
  assign sel_word = (item.reg_addr == pic_pkg::ADDR_EDGE_HI) ?
                    {item.write_data, lo_word[7:0]} : {lo_word[15:8], item.write_data};
  assign mask_word = (item.reg_addr == pic_pkg::ADDR_MASK_HI) ?
                     {item.write_data, st.mask_bits[7:0]} :
                     {st.mask_bits[15:8], item.write_data};

  assign edge_req = (st.line_levels & ~sel_word) | (st.request_bits & st.edge_select & sel_word);
  assign mask_req = (st.request_bits & ~mask_word & st.edge_select) |
                    (st.line_levels & ~mask_word & ~st.edge_select);
  assign fall_req = st.request_bits & ~line_bit;
  assign rise_cmp = (|(st.group_bits & line_bit)) ?
                    ((st.request_bits | st.service_bits) & st.group_bits) :
                    (st.request_bits | st.service_bits);

  always_comb begin
    st_next           = st;
    result.vector_out = 8'h00;
    result.read_data  = 8'h00;
    result.spurious   = 1'b0;
    unique case (item.cmd)
      pic_pkg::CMD_LINE: begin
        if (!(|(st.line_levels & line_bit)) && item.line_level) begin
          st_next.line_levels = st.line_levels | line_bit;
          if (!(|(st.request_bits & line_bit)) && !(|(st.mask_bits & line_bit))) begin
            st_next.request_bits = st.request_bits | line_bit;
            if (!st.illegal_flag && line_bit > rise_cmp) begin
              st_next.int_state = 1'b1;
            end
          end
        end else if ((|(st.line_levels & line_bit)) && !item.line_level) begin
          st_next.line_levels = st.line_levels & ~line_bit;
          if (!(|(st.edge_select & line_bit)) && (|(st.request_bits & line_bit))) begin
            st_next.request_bits = fall_req;
            if (!st.illegal_flag) begin
              st_next.int_state = pic_pkg::should_int(fall_req, st.service_bits,
                                                      st.group_bits, 1'b0);
            end
          end
        end
      end
      pic_pkg::CMD_ACK: begin
        st_next.int_state = 1'b0;
        if (ack_found) begin
          if (|(st.edge_select & ack_bit)) begin
            st_next.request_bits = st.request_bits & ~ack_bit;
          end
          st_next.service_bits = st.service_bits | ack_bit;
          result.vector_out    = {st.vector_base, ack_lvl, 1'b0};
        end else begin
          st_next.illegal_flag = 1'b1;
          result.spurious      = 1'b1;
          result.vector_out    = {st.vector_base, 5'd0};
        end
      end
      pic_pkg::CMD_EOI: begin
        if (st.illegal_flag) begin
          st_next.illegal_flag = 1'b0;
          st_next.int_state = pic_pkg::should_int(st.request_bits, st.service_bits,
                                                  st.group_bits, 1'b0);
        end else if (st.service_bits != 16'h0000) begin
          st_next.service_bits = st.service_bits & ~eoi_bit;
          st_next.int_state = pic_pkg::should_int(st.request_bits, st.service_bits & ~eoi_bit,
                                                  st.group_bits, 1'b0);
        end
      end
      pic_pkg::CMD_WRITE: begin
        unique case (item.reg_addr)
          pic_pkg::ADDR_EDGE_LO, pic_pkg::ADDR_EDGE_HI: begin
            if (st.vector_set) begin
              if (sel_word != st.group_bits) begin
                st_next.group_bits = sel_word;
                if (!st.illegal_flag && st.service_bits != 16'h0000) begin
                  st_next.int_state = pic_pkg::should_int(st.request_bits, st.service_bits,
                                                          sel_word, 1'b0);
                end
              end
            end else begin
              st_next.edge_select  = sel_word;
              st_next.request_bits = edge_req;
              if (edge_req != st.request_bits) begin
                st_next.int_state = pic_pkg::should_int(edge_req, st.service_bits,
                                                        st.group_bits, st.illegal_flag);
              end
            end
          end
          pic_pkg::ADDR_MASK_LO, pic_pkg::ADDR_MASK_HI: begin
            if (item.reg_addr == pic_pkg::ADDR_MASK_HI && !st.vector_set) begin
              st_next.vector_base = item.write_data[7:5];
              st_next.vector_set  = 1'b1;
            end else begin
              st_next.mask_bits    = mask_word;
              st_next.request_bits = mask_req;
              if (mask_req != st.request_bits) begin
                st_next.int_state = pic_pkg::should_int(mask_req, st.service_bits,
                                                        st.group_bits, st.illegal_flag);
              end
            end
          end
          default: begin
          end
        endcase
      end
      pic_pkg::CMD_READ: begin
        unique case (item.reg_addr)
          pic_pkg::ADDR_SRV_LO:  result.read_data = st.service_bits[7:0];
          pic_pkg::ADDR_SRV_HI:  result.read_data = st.service_bits[15:8];
          pic_pkg::ADDR_RMSK_LO: result.read_data = st.mask_bits[7:0];
          pic_pkg::ADDR_RMSK_HI: result.read_data = st.mask_bits[15:8];
          default:               result.read_data = 8'h00;
        endcase
      end
      default: begin
      end
    endcase
    result.int_out = st_next.int_state;
  end

endmodule

// ===== bench/tb_prioritized_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// tb_prioritized_interrupt_controller
// Self-checking bench for the sixteen-source interrupt controller. A tracker
// class mirrors the controller registers, turns every accepted command beat
// into the response it must cause, and compares the response beats in order.
// Stimulus is a directed opening, random traffic, a directed run around the
// vector write and more random traffic, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_prioritized_interrupt_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  class pic_tracker;
    bit [15:0] lines, pend, insvc, msk, edg, grp;
    bit [2:0]  vbase;
    bit        halted, vec_locked, irq;
    rsp_t      due[$];
    int        errors;

    function new();
      lines = '0; pend = '0; insvc = '0; msk = 16'hffff;
      edg = '0; grp = '0; vbase = '0;
      halted = 0; vec_locked = 0; irq = 0;
      errors = 0;
    endfunction

    function int highest(bit [15:0] v);
      for (int i = 15; i >= 0; i--) begin
        if (v[i]) begin
          return i;
        end
      end
      return -1;
    endfunction

    function bit want_irq();
      bit [15:0] hp_req;
      bit [15:0] hp_srv;
      hp_req = pend & grp;
      hp_srv = insvc & grp;
      if (halted) begin
        return 1'b0;
      end
      if (hp_req != 0 || hp_srv != 0) begin
        return (pend & ~insvc & grp) > hp_srv;
      end
      return (pend & ~insvc) > insvc;
    endfunction

    function void load_mask(bit [15:0] d);
      bit [15:0] prev;
      prev = pend;
      msk = d;
      pend = (pend & ~d & edg) | (lines & ~d & ~edg);
      if (pend != prev) irq = want_irq();
    endfunction

    function void load_edge(bit [15:0] d);
      bit [15:0] prev;
      prev = pend;
      pend = (lines & ~d) | (pend & edg & d);
      edg = d;
      if (pend != prev) irq = want_irq();
    endfunction

    function void load_group(bit [15:0] d);
      if (grp != d) begin
        grp = d;
        if (!halted && insvc != 0) irq = want_irq();
      end
    endfunction

    function void line_change(bit [3:0] n, bit lv);
      bit [15:0] b;
      bit [15:0] old;
      bit [15:0] cmp;
      b = 16'h0001 << n;
      if ((lines & b) == 0 && lv) begin
        lines |= b;
        if ((pend & b) == 0 && (msk & b) == 0) begin
          old = pend | insvc;
          cmp = ((grp & b) != 0) ? (old & grp) : old;
          pend |= b;
          if (!halted && b > cmp) irq = 1'b1;
        end
      end else if ((lines & b) != 0 && !lv) begin
        lines &= ~b;
        if ((edg & b) == 0 && (pend & b) != 0) begin
          pend &= ~b;
          if (!halted) irq = want_irq();
        end
      end
    endfunction

    function bit [7:0] acknowledge(output bit bad);
      int        lvl;
      bit [15:0] hp_req;
      bit [15:0] hp_srv;
      bit [15:0] b;
      lvl = -1;
      hp_req = pend & grp;
      hp_srv = insvc & grp;
      if (hp_req != 0) begin
        lvl = highest(hp_req);
        b = 16'h0001 << lvl;
        if (b < hp_srv) lvl = -1;
      end else if (pend != 0 && hp_srv == 0) begin
        lvl = highest(pend);
        b = 16'h0001 << lvl;
        if (b < insvc) lvl = -1;
      end
      irq = 1'b0;
      if (lvl >= 0) begin
        b = 16'h0001 << lvl;
        if ((edg & b) != 0) pend &= ~b;
        insvc |= b;
        bad = 1'b0;
        return {vbase, 4'(lvl), 1'b0};
      end
      halted = 1'b1;
      bad = 1'b1;
      return {vbase, 5'b00000};
    endfunction

    function void end_of_service();
      bit [15:0] hi;
      int        lvl;
      if (halted) begin
        halted = 1'b0;
      end else if (insvc != 0) begin
        hi = insvc & grp;
        lvl = highest(hi != 0 ? hi : insvc);
        insvc &= ~(16'h0001 << lvl);
      end else begin
        return;
      end
      irq = want_irq();
    endfunction

    function void write_byte(bit [1:0] addr, bit [7:0] d);
      case (addr)
        ADDR_EDGE_LO: begin
          if (vec_locked) load_group({grp[15:8], d});
          else load_edge({edg[15:8], d});
        end
        ADDR_EDGE_HI: begin
          if (vec_locked) load_group({d, grp[7:0]});
          else load_edge({d, edg[7:0]});
        end
        ADDR_MASK_LO: load_mask({msk[15:8], d});
        default: begin
          if (vec_locked) begin
            load_mask({d, msk[7:0]});
          end else begin
            vbase = d[7:5];
            vec_locked = 1'b1;
          end
        end
      endcase
    endfunction

    function bit [7:0] read_byte(bit [1:0] addr);
      case (addr)
        ADDR_SRV_LO:  return insvc[7:0];
        ADDR_SRV_HI:  return insvc[15:8];
        ADDR_RMSK_LO: return msk[7:0];
        default:      return msk[15:8];
      endcase
    endfunction

    function void take_command(req_t c);
      rsp_t e;
      bit   bad;
      e = '0;
      case (c.cmd)
        CMD_LINE:  line_change(c.line_number, c.line_level);
        CMD_ACK: begin
          e.vector_out = acknowledge(bad);
          e.spurious = bad;
        end
        CMD_EOI:   end_of_service();
        CMD_WRITE: write_byte(c.reg_addr, c.write_data);
        CMD_READ:  e.read_data = read_byte(c.reg_addr);
        default: ;
      endcase
      e.int_out = irq;
      due.push_back(e);
    endfunction

    function void compare_response(rsp_t a);
      rsp_t e;
      if (due.size() == 0) begin
        $error("response beat with none outstanding: %h", a);
        errors++;
        return;
      end
      e = due.pop_front();
      if (a.int_out !== e.int_out) begin
        $error("int_out: expected %0d, actual %0d", e.int_out, a.int_out);
        errors++;
      end
      if (a.vector_out !== e.vector_out) begin
        $error("vector_out: expected %02h, actual %02h", e.vector_out, a.vector_out);
        errors++;
      end
      if (a.read_data !== e.read_data) begin
        $error("read_data: expected %02h, actual %02h", e.read_data, a.read_data);
        errors++;
      end
      if (a.spurious !== e.spurious) begin
        $error("spurious: expected %0d, actual %0d", e.spurious, a.spurious);
        errors++;
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  bit         calm = 1'b0;
  int         stall_left = 0;
  pic_tracker trk;

  prioritized_interrupt_controller dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      trk.compare_response(rsp);
    end
    if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic req_t mk(logic [2:0] cmd, logic [3:0] line, logic lv,
                              logic [1:0] addr, logic [7:0] data);
    req_t r;
    r.cmd = cmd;
    r.line_number = line;
    r.line_level = lv;
    r.reg_addr = addr;
    r.write_data = data;
    return r;
  endfunction

  task automatic send(req_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    trk.take_command(r);
  endtask

  // pre: vector not yet written, so address 3 writes are held back
  function automatic req_t gen_item(bit pre);
    req_t r;
    int   pick;
    r = req_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.cmd = CMD_LINE;
      if ($urandom_range(0, 3) != 0) r.line_level = ~trk.lines[r.line_number];
    end else if (pick < 60) begin
      r.cmd = CMD_ACK;
    end else if (pick < 72) begin
      r.cmd = CMD_EOI;
    end else if (pick < 87) begin
      r.cmd = CMD_WRITE;
      if (pre && r.reg_addr == ADDR_MASK_HI) r.reg_addr = ADDR_MASK_LO;
      if ((r.reg_addr == ADDR_MASK_LO || r.reg_addr == ADDR_MASK_HI) &&
          $urandom_range(0, 4) < 3) begin
        r.write_data = 8'($urandom & $urandom & $urandom);
      end
    end else if (pick < 97) begin
      r.cmd = CMD_READ;
    end else begin
      r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return r;
  endfunction

  task automatic random_run(int n, bit pre);
    for (int i = 0; i < n; i++) begin
      send(gen_item(pre));
    end
  endtask

  task automatic directed_early();
    send(mk(CMD_READ, 4'd0, 1'b0, ADDR_RMSK_LO, 8'h00));
    send(mk(CMD_READ, 4'd0, 1'b0, ADDR_RMSK_HI, 8'h00));
    send(mk(CMD_ACK, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_LINE, 4'd15, 1'b1, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_EOI, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_EOI, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_MASK_LO, 8'h00));
    send(mk(CMD_LINE, 4'd3, 1'b1, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_LINE, 4'd3, 1'b1, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_EDGE_LO, 8'hff));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_EDGE_HI, 8'h80));
  endtask

  task automatic directed_late();
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_MASK_HI, 8'he0));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_MASK_HI, 8'h00));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_MASK_LO, 8'h00));
    send(mk(CMD_LINE, 4'd15, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_LINE, 4'd15, 1'b1, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_LINE, 4'd0, 1'b1, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_ACK, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h01));
    send(mk(CMD_ACK, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_WRITE, 4'd0, 1'b0, ADDR_EDGE_HI, 8'hff));
    send(mk(CMD_READ, 4'd0, 1'b0, ADDR_SRV_HI, 8'h00));
    send(mk(CMD_EOI, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_READ, 4'd0, 1'b0, ADDR_SRV_LO, 8'h00));
    send(mk(CMD_SPARE_LO, 4'd0, 1'b0, ADDR_EDGE_LO, 8'h00));
    send(mk(CMD_SPARE_HI, 4'd15, 1'b1, ADDR_MASK_HI, 8'hff));
  endtask

  initial begin
    trk = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_early();
    random_run(100, 1'b1);
    directed_late();
    random_run(340, 1'b0);
    calm = 1'b1;
    random_run(80, 1'b0);
    req_valid <= 1'b0;
    while (trk.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (trk.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
